>>> rtl/cse_pkg.sv
package cse_pkg;

  localparam int COUNT_WIDTH = 17;
  localparam int LIMIT_WIDTH = 16;
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;
  localparam int LEN_WIDTH   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LOW_PRINT  = 8'd32;
  localparam logic [7:0] CH_HIGH_PRINT = 8'd126;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;

  typedef enum logic [2:0] {
    KIND_ERR,
    KIND_DOTS,
    KIND_ESC2,
    KIND_HEX,
    KIND_PLAIN,
    KIND_TERM
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       term;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_wr_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    case (nib & NIBBLE_MASK)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/cse_front.sv
module cse_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cse_pkg::LIMIT_WIDTH-1:0] output_limit,
  input  logic                           data_valid,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  input  logic                           queue_full,
  output logic                           data_stall,
  output cse_pkg::q_wr_t                 q_wr
);

  logic [cse_pkg::COUNT_WIDTH-1:0] emitted_length;
  logic [cse_pkg::COUNT_WIDTH-1:0] emitted_length_next;
  logic                            truncated;
  logic                            truncated_next;

  logic                            accept;
  logic                            limit_bad;
  logic                            simple_esc;
  logic [cse_pkg::LEN_WIDTH-1:0]   len;
  logic [cse_pkg::CMP_WIDTH-1:0]   sum;
  logic [cse_pkg::CMP_WIDTH-1:0]   thresh;
  logic                            over;
  logic [cse_pkg::LEN_WIDTH-1:0]   amount;
  logic [cse_pkg::COUNT_WIDTH:0]   added;
  cse_pkg::job_t                   job;
  logic                            push;

  assign data_stall = queue_full;
  assign accept     = data_valid && !data_stall;
  assign limit_bad  = (output_limit == cse_pkg::LIMIT_WIDTH'(1)) ||
                      (output_limit == cse_pkg::LIMIT_WIDTH'(2));

  always_comb begin
    simple_esc = (data_byte == cse_pkg::CH_BSLASH) || (data_byte == cse_pkg::CH_QUOTE) ||
                 (data_byte == cse_pkg::CH_TAB) || (data_byte == cse_pkg::CH_CR) ||
                 (data_byte == cse_pkg::CH_LF);
    if ((data_byte == cse_pkg::CH_NUL) || simple_esc) begin
      len = cse_pkg::LEN_WIDTH'(2);
    end else if ((data_byte < cse_pkg::CH_LOW_PRINT) || (data_byte > cse_pkg::CH_HIGH_PRINT)) begin
      len = cse_pkg::LEN_WIDTH'(4);
    end else begin
      len = cse_pkg::LEN_WIDTH'(1);
    end
    sum    = cse_pkg::CMP_WIDTH'(emitted_length) + cse_pkg::CMP_WIDTH'(len);
    thresh = cse_pkg::CMP_WIDTH'(output_limit) - cse_pkg::CMP_WIDTH'(3);
    over   = (output_limit != '0) && (sum > thresh);
    amount = over ? cse_pkg::LEN_WIDTH'(3) : len;
    added  = {1'b0, emitted_length} + (cse_pkg::COUNT_WIDTH + 1)'(amount);
  end

  always_comb begin
    job.term = last_byte;
    job.data = data_byte;
    job.kind = cse_pkg::KIND_PLAIN;
    push     = 1'b1;
    emitted_length_next = emitted_length;
    truncated_next      = truncated;
    if (limit_bad) begin
      job.kind = cse_pkg::KIND_ERR;
      job.term = 1'b0;
    end else if (truncated) begin
      job.kind = cse_pkg::KIND_TERM;
      push     = last_byte;
    end else begin
      if (added[cse_pkg::COUNT_WIDTH]) begin
        emitted_length_next = '1;
      end else begin
        emitted_length_next = added[cse_pkg::COUNT_WIDTH-1:0];
      end
      if (over) begin
        job.kind       = cse_pkg::KIND_DOTS;
        truncated_next = 1'b1;
      end else if (data_byte == cse_pkg::CH_NUL) begin
        job.kind = cse_pkg::KIND_ESC2;
        job.data = cse_pkg::CH_DIGIT0;
      end else if (simple_esc) begin
        job.kind = cse_pkg::KIND_ESC2;
        if (data_byte == cse_pkg::CH_TAB) begin
          job.data = cse_pkg::CH_T;
        end else if (data_byte == cse_pkg::CH_CR) begin
          job.data = cse_pkg::CH_R;
        end else if (data_byte == cse_pkg::CH_LF) begin
          job.data = cse_pkg::CH_N;
        end
      end else if (len == cse_pkg::LEN_WIDTH'(4)) begin
        job.kind = cse_pkg::KIND_HEX;
      end
    end
    if (last_byte) begin
      emitted_length_next = '0;
      truncated_next      = 1'b0;
    end
  end

  assign q_wr.valid = accept && push;
  assign q_wr.job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_length <= '0;
      truncated      <= 1'b0;
    end else if (accept) begin
      emitted_length <= emitted_length_next;
      truncated      <= truncated_next;
    end
  end

endmodule

>>> rtl/cse_queue.sv
module cse_queue (
  input  logic           clk,
  input  logic           rst,
  input  cse_pkg::q_wr_t q_wr,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output cse_pkg::job_t  head
);

  cse_pkg::job_t                  slots [cse_pkg::QUEUE_DEPTH];
  logic [cse_pkg::QPTR_WIDTH-1:0] wr_ptr;
  logic [cse_pkg::QPTR_WIDTH-1:0] rd_ptr;
  logic [cse_pkg::QCNT_WIDTH-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign full      = (count == cse_pkg::QCNT_WIDTH'(cse_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = q_wr.valid && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        if (wr_ptr == cse_pkg::QPTR_WIDTH'(cse_pkg::QUEUE_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_ptr == cse_pkg::QPTR_WIDTH'(cse_pkg::QUEUE_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/cse_back.sv
module cse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_avail,
  input  cse_pkg::job_t job,
  output logic          pop,
  output logic          char_valid,
  input  logic          char_stall,
  output logic [7:0]    out_char,
  output logic          last_of_run,
  output logic          limit_error
);

  logic [cse_pkg::LEN_WIDTH-1:0] idx;
  logic [cse_pkg::LEN_WIDTH-1:0] body_len;
  logic [cse_pkg::LEN_WIDTH-1:0] total;
  logic [7:0]                    body_char;
  logic [7:0]                    char_next;
  logic                          advance;
  logic                          fire;
  logic                          done;

  always_comb begin
    body_char = job.data;
    case (job.kind)
      cse_pkg::KIND_ERR: begin
        body_len  = cse_pkg::LEN_WIDTH'(1);
        body_char = cse_pkg::CH_NUL;
      end
      cse_pkg::KIND_DOTS: begin
        body_len  = cse_pkg::LEN_WIDTH'(3);
        body_char = cse_pkg::CH_DOT;
      end
      cse_pkg::KIND_ESC2: begin
        body_len = cse_pkg::LEN_WIDTH'(2);
        if (idx == '0) begin
          body_char = cse_pkg::CH_BSLASH;
        end
      end
      cse_pkg::KIND_HEX: begin
        body_len = cse_pkg::LEN_WIDTH'(4);
        case (idx)
          cse_pkg::LEN_WIDTH'(0): body_char = cse_pkg::CH_BSLASH;
          cse_pkg::LEN_WIDTH'(1): body_char = cse_pkg::CH_X;
          cse_pkg::LEN_WIDTH'(2): body_char = cse_pkg::hex_char(job.data[7:4]);
          default:                body_char = cse_pkg::hex_char(job.data[3:0]);
        endcase
      end
      cse_pkg::KIND_PLAIN: begin
        body_len = cse_pkg::LEN_WIDTH'(1);
      end
      default: begin
        body_len = '0;
      end
    endcase
    total     = body_len + cse_pkg::LEN_WIDTH'(job.term);
    char_next = (idx < body_len) ? body_char : cse_pkg::CH_NUL;
  end

  assign advance = !char_valid || !char_stall;
  assign fire    = advance && job_avail;
  assign done    = fire && (idx == total - 1'b1);
  assign pop     = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx        <= '0;
    end else if (advance) begin
      char_valid <= job_avail;
      if (job_avail) begin
        out_char    <= char_next;
        last_of_run <= (idx == total - 1'b1);
        limit_error <= (job.kind == cse_pkg::KIND_ERR);
        idx         <= done ? '0 : idx + 1'b1;
      end
    end
  end

endmodule

>>> rtl/c_string_byte_escaper_core.sv
// Escapes a byte string into C literal text, one input byte per transaction and one
// output character per transaction, with last_of_run on the final character of each
// input byte. A byte yields 0 to 5 output characters (none when it is dropped after
// truncation, a zero for limit 1 or 2; otherwise plain, two-character escape, \xHH or
// "..." on truncation, plus the terminator on the last byte); the output register
// delivers one character per unstalled cycle, so the result channel sets the rate. A
// two-entry queue between the classifier and the character generator lets input keep
// flowing while a long escape drains. Write output_limit only while the block is idle.
module c_string_byte_escaper_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            output_limit_we,
  input  logic [cse_pkg::LIMIT_WIDTH-1:0] output_limit_wdata,
  input  logic                            data_valid,
  output logic                            data_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  output logic                            char_valid,
  input  logic                            char_stall,
  output logic [7:0]                      out_char,
  output logic                            last_of_run,
  output logic                            limit_error
);

  logic [cse_pkg::LIMIT_WIDTH-1:0] output_limit;
  cse_pkg::q_wr_t                  q_wr;
  cse_pkg::job_t                   head;
  logic                            q_full;
  logic                            q_not_empty;
  logic                            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= '0;
    end else if (output_limit_we) begin
      output_limit <= output_limit_wdata;
    end
  end

  cse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .output_limit (output_limit),
    .data_valid   (data_valid),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .queue_full   (q_full),
    .data_stall   (data_stall),
    .q_wr         (q_wr)
  );

  cse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_wr      (q_wr),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  cse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_avail   (q_not_empty),
    .job         (head),
    .pop         (q_pop),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .limit_error (limit_error)
  );

`ifndef NO_ASSERTIONS
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (char_valid && limit_error) |-> (out_char == 8'h00 && last_of_run))
    else $error("Error transaction must be a single zero character.");

  a_nul_is_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && out_char == 8'h00) |-> last_of_run)
    else $error("A zero character must close its run.");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !q_not_empty |-> !data_stall)
    else $error("Input stalled while the queue is empty.");
`endif

endmodule

>>> tb/c_string_escape_checker.sv
module c_string_escape_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            output_limit_we,
  input  logic [cse_pkg::LIMIT_WIDTH-1:0] output_limit_wdata,
  input  logic                            data_valid,
  input  logic                            data_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  input  logic                            char_valid,
  input  logic                            char_stall,
  input  logic [7:0]                      out_char,
  input  logic                            last_of_run,
  input  logic                            limit_error,
  output int                              fail_count,
  output int                              pending_chars
);

  localparam int RUN_MAX = (1 << cse_pkg::COUNT_WIDTH) - 1;
  localparam logic [7:0] UPPER_A = 8'h41;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } escape_char_t;

  escape_char_t                    expected_chars[$];
  logic [cse_pkg::LIMIT_WIDTH-1:0] limit_reg;
  int                              run_length;
  logic                            run_truncated;

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return cse_pkg::CH_DIGIT0 + 8'(nib);
    end
    return UPPER_A + 8'(nib) - 8'd10;
  endfunction

  function automatic int grow_run(input int amount);
    return (run_length + amount > RUN_MAX) ? RUN_MAX : run_length + amount;
  endfunction

  // Works out the characters one input byte spells and queues them in order.
  task automatic predict_escape(input logic [7:0] b, input logic lst);
    escape_char_t spelled[$];
    int           width;
    logic [7:0]   second;
    spelled = {};
    if (limit_reg == 16'd1 || limit_reg == 16'd2) begin
      expected_chars.push_back(escape_char_t'{cse_pkg::CH_NUL, 1'b1, 1'b1});
      if (lst) begin
        run_length = 0;
        run_truncated = 1'b0;
      end
      return;
    end
    if (!run_truncated) begin
      width = 1;
      second = b;
      case (b)
        cse_pkg::CH_NUL: begin
          width = 2;
          second = cse_pkg::CH_DIGIT0;
        end
        cse_pkg::CH_BSLASH, cse_pkg::CH_QUOTE: begin
          width = 2;
        end
        cse_pkg::CH_TAB: begin
          width = 2;
          second = cse_pkg::CH_T;
        end
        cse_pkg::CH_CR: begin
          width = 2;
          second = cse_pkg::CH_R;
        end
        cse_pkg::CH_LF: begin
          width = 2;
          second = cse_pkg::CH_N;
        end
        default: begin
          if (b < cse_pkg::CH_LOW_PRINT || b > cse_pkg::CH_HIGH_PRINT) width = 4;
        end
      endcase
      if (limit_reg != '0 && run_length + width > int'(limit_reg) - 3) begin
        run_truncated = 1'b1;
        repeat (3) spelled.push_back(escape_char_t'{cse_pkg::CH_DOT, 1'b0, 1'b0});
        run_length = grow_run(3);
      end else begin
        if (width == 1) begin
          spelled.push_back(escape_char_t'{b, 1'b0, 1'b0});
        end else if (width == 2) begin
          spelled.push_back(escape_char_t'{cse_pkg::CH_BSLASH, 1'b0, 1'b0});
          spelled.push_back(escape_char_t'{second, 1'b0, 1'b0});
        end else begin
          spelled.push_back(escape_char_t'{cse_pkg::CH_BSLASH, 1'b0, 1'b0});
          spelled.push_back(escape_char_t'{cse_pkg::CH_X, 1'b0, 1'b0});
          spelled.push_back(escape_char_t'{nibble_char(b[7:4]), 1'b0, 1'b0});
          spelled.push_back(escape_char_t'{nibble_char(b[3:0]), 1'b0, 1'b0});
        end
        run_length = grow_run(width);
      end
    end
    if (lst) begin
      spelled.push_back(escape_char_t'{cse_pkg::CH_NUL, 1'b0, 1'b0});
      run_length = 0;
      run_truncated = 1'b0;
    end
    if (spelled.size() > 0) begin
      spelled[spelled.size() - 1].last = 1'b1;
    end
    foreach (spelled[i]) expected_chars.push_back(spelled[i]);
  endtask

  always @(posedge clk) begin
    escape_char_t want;
    if (rst) begin
      limit_reg = '0;
      run_length = 0;
      run_truncated = 1'b0;
      expected_chars.delete();
      fail_count = 0;
    end else begin
      if (output_limit_we) limit_reg = output_limit_wdata;
      if (char_valid && !char_stall) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character transaction: out_char %0h", out_char);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %0h, actual %0h", want.ch, out_char);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
            fail_count++;
          end
          if (limit_error !== want.err) begin
            $error("limit_error: expected %0b, actual %0b", want.err, limit_error);
            fail_count++;
          end
        end
      end
      if (data_valid && !data_stall) predict_escape(data_byte, last_byte);
    end
    pending_chars = expected_chars.size();
  end

endmodule

>>> tb/c_string_byte_escaper_core_tb.sv
module c_string_byte_escaper_core_tb;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 38;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            output_limit_we;
  logic [cse_pkg::LIMIT_WIDTH-1:0] output_limit_wdata;
  logic                            data_valid;
  logic                            data_stall;
  logic [7:0]                      data_byte;
  logic                            last_byte;
  logic                            char_valid;
  logic                            char_stall;
  logic [7:0]                      out_char;
  logic                            last_of_run;
  logic                            limit_error;
  int                              fail_count;
  int                              pending_chars;
  logic                            idle_on;
  int                              stall_left;
  int                              quiet_cycles;

  always #1 clk = ~clk;

  c_string_byte_escaper_core dut (
    .clk                (clk),
    .rst                (rst),
    .output_limit_we    (output_limit_we),
    .output_limit_wdata (output_limit_wdata),
    .data_valid         (data_valid),
    .data_stall         (data_stall),
    .data_byte          (data_byte),
    .last_byte          (last_byte),
    .char_valid         (char_valid),
    .char_stall         (char_stall),
    .out_char           (out_char),
    .last_of_run        (last_of_run),
    .limit_error        (limit_error)
  );

  c_string_escape_checker escape_check (
    .clk                (clk),
    .rst                (rst),
    .output_limit_we    (output_limit_we),
    .output_limit_wdata (output_limit_wdata),
    .data_valid         (data_valid),
    .data_stall         (data_stall),
    .data_byte          (data_byte),
    .last_byte          (last_byte),
    .char_valid         (char_valid),
    .char_stall         (char_stall),
    .out_char           (out_char),
    .last_of_run        (last_of_run),
    .limit_error        (limit_error),
    .fail_count         (fail_count),
    .pending_chars      (pending_chars)
  );

  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      char_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      char_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      char_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (char_valid && !char_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[6];
    specials = '{cse_pkg::CH_NUL, cse_pkg::CH_BSLASH, cse_pkg::CH_QUOTE, cse_pkg::CH_TAB,
                 cse_pkg::CH_CR, cse_pkg::CH_LF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
      5, 6: return specials[$urandom_range(0, 5)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= lst;
    do @(posedge clk); while (data_stall);
  endtask

  task automatic settle();
    data_valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [cse_pkg::LIMIT_WIDTH-1:0] value);
    output_limit_we    <= 1'b1;
    output_limit_wdata <= value;
    @(posedge clk);
    output_limit_we    <= 1'b0;
  endtask

  // Strings of random length; the count may run out mid-string, which leaves
  // the string open across the next limit change.
  task automatic send_text(input int items);
    int left;
    int len;
    left = items;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < len && left > 0; k++) begin
        send_byte(pick_byte(), k == len - 1);
        left--;
      end
    end
  endtask

  initial begin
    logic [7:0]                      tour[13];
    logic [cse_pkg::LIMIT_WIDTH-1:0] limits[PHASES];
    tour = '{8'h00, cse_pkg::CH_BSLASH, cse_pkg::CH_QUOTE, cse_pkg::CH_TAB, cse_pkg::CH_CR,
             cse_pkg::CH_LF, 8'h01, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF};
    limits = '{16'd0, 16'd5, 16'd1, 16'd12, 16'd3, 16'd2, 16'd65535, 16'd4,
               cse_pkg::LIMIT_WIDTH'($urandom_range(3, 60)), 16'd30, 16'd0};
    rst                <= 1'b1;
    idle_on            <= 1'b1;
    output_limit_we    <= 1'b0;
    output_limit_wdata <= '0;
    data_valid         <= 1'b0;
    data_byte          <= '0;
    last_byte          <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tour[i]) send_byte(tour[i], i == 12);
    settle();
    write_limit(16'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    settle();
    write_limit(16'd1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    settle();
    write_limit(16'd2);
    send_byte(8'h43, 1'b1);
    settle();
    write_limit(16'd8);
    send_byte(8'h01, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p >= PHASES - 2) idle_on <= 1'b0;
      write_limit(limits[p]);
      send_text(PHASE_ITEMS);
    end

    settle();
    if (fail_count == 0 && pending_chars == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cse_pkg.sv
rtl/cse_front.sv
rtl/cse_queue.sv
rtl/cse_back.sv
rtl/c_string_byte_escaper_core.sv
tb/c_string_escape_checker.sv
tb/c_string_byte_escaper_core_tb.sv
